// ===== src/pcih_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcih_pkg: shared types and constants of the per-column histogram
// Holds the input kind codes, sample type codes, register indexes, the
// command and status bundles between controller and datapath, and the
// bin and label mapping functions.
// ----------------------------------------------------------------------------
package pcih_pkg;

  // Width of the configuration register index.
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_TYPE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_LENGTH = 2'd1;

  // Input item kinds.
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Sample types.
  localparam logic [1:0] TYPE_S8  = 2'd0;
  localparam logic [1:0] TYPE_U8  = 2'd1;
  localparam logic [1:0] TYPE_S16 = 2'd2;
  localparam logic [1:0] TYPE_U16 = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;   // Write one zero entry of the reset clearing pass.
    logic accept;     // An input item is transferred this cycle.
    logic inc_write;  // Write back the incremented count of a sample.
    logic rd_finish;  // Load the result register and clear the bin if asked.
  } pcih_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;          // Kind of the item on the input channel.
    logic       pos_in_range;  // Current column lies within the build.
    logic       out_free;      // Result register can take a new result.
    logic       clr_last;      // Clearing pass is at its last entry.
  } pcih_status_t;

  // Map raw sample bits to an offset bin value for the given type.
  function automatic logic [15:0] raw_bin(input logic [1:0] stype, input logic [15:0] raw);
    logic [15:0] b;
    case (stype)
      TYPE_S8:  b = {8'h00, raw[7:0] ^ 8'h80};
      TYPE_U8:  b = {8'h00, raw[7:0]};
      TYPE_S16: b = raw ^ 16'h8000;
      default:  b = raw;
    endcase
    return b;
  endfunction

  // Sample value that a bin stands for.
  function automatic logic signed [16:0] bin_label(input logic [1:0] stype,
                                                   input logic [16:0] bin);
    logic [16:0] v;
    case (stype)
      TYPE_S8:  v = bin - 17'd128;
      TYPE_S16: v = bin - 17'h08000;
      default:  v = bin;
    endcase
    return signed'(v);
  endfunction

endpackage

// ===== src/pcih_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcih_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module pcih_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pcih_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcih_ctrl: histogram controller
// Sequences the reset clearing pass, input transfers, the read-modify-write
// of a sample and the delivery of a bin read.
// ----------------------------------------------------------------------------
module pcih_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pcih_pkg::pcih_status_t status_i,
  output pcih_pkg::pcih_cmd_t    cmd_o
);
  import pcih_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_INC   = 4'b0100,
    ST_READ  = 4'b1000
  } pcih_state_e;

  pcih_state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (status_i.kind == KIND_SAMPLE && status_i.pos_in_range) begin
            state_d = ST_INC;
          end else if (status_i.kind == KIND_READ) begin
            state_d = ST_READ;
          end
        end
      end
      ST_INC: begin
        cmd_o.inc_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_READ: begin
        if (status_i.out_free) begin
          cmd_o.rd_finish = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/pcih_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcih_dp: histogram datapath
// Holds the configuration registers, position counters, sticky flags, the
// bin count memory with its clearing counter, and the result register.
// ----------------------------------------------------------------------------
module pcih_dp #(
  parameter int BIN_BITS    = 16,
  parameter int MAX_COLUMNS = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pcih_pkg::pcih_cmd_t               cmd_i,
  output pcih_pkg::pcih_status_t            status_o,
  input  logic [1:0]                        kind_i,
  input  logic [15:0]                       sample_raw_i,
  input  logic [1:0]                        read_column_i,
  input  logic [15:0]                       read_bin_i,
  input  logic                              clear_after_read_i,
  input  logic                              cfg_valid_i,
  input  logic [pcih_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [31:0]                       bin_count_o,
  output logic signed [16:0]                bin_label_o,
  output logic                              samples_dropped_o,
  output logic                              count_saturated_o
);
  import pcih_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS << BIN_BITS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COLP_W = $clog2(MAX_COLUMNS + 1);
  localparam logic [COLP_W-1:0]      MaxColP   = COLP_W'(MAX_COLUMNS);
  localparam logic [6:0]             MaxColRd  = 7'(MAX_COLUMNS);
  localparam logic [COUNT_WIDTH-1:0] CountMax  = {COUNT_WIDTH{1'b1}};
  localparam logic [ADDR_W-1:0]      LastAddr  = ADDR_W'(DEPTH - 1);

  // Configuration registers.
  logic [1:0]  type_q, type_d;
  logic [31:0] len_q, len_d;

  // Position counters and sticky flags.
  logic [31:0]       row_q, row_d;
  logic [COLP_W-1:0] col_q, col_d;
  logic              dropped_q, dropped_d;
  logic              sat_q, sat_d;

  // Clearing counter.
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  // Per-item latched payload.
  logic [ADDR_W-1:0]        addr_q;
  logic signed [16:0]       label_q;
  logic                     col_ok_q;
  logic                     clr_rd_q;

  // Result register.
  logic                     out_valid_q, out_valid_d;
  logic [31:0]              cnt_out_q;
  logic signed [16:0]       label_out_q;
  logic                     drop_out_q;
  logic                     sat_out_q;

  // Memory ports.
  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0]   ram_wdata, ram_rdata;

  // Address and count helpers.
  logic [BIN_BITS-1:0]      smp_bin, rd_bin;
  logic [ADDR_W-1:0]        smp_addr, rd_addr;
  logic                     is_sample, is_read, pos_in_range, rd_col_ok;
  logic [COUNT_WIDTH-1:0]   inc_cnt, rd_cnt;
  logic [63:0]              rd_cnt_ext;
  logic                     row_wrap;

  // Bin index and memory address of the incoming item.
  assign smp_bin      = BIN_BITS'(raw_bin(type_q, sample_raw_i));
  assign rd_bin       = BIN_BITS'(raw_bin(type_q, read_bin_i));
  assign smp_addr     = (ADDR_W'(col_q) << BIN_BITS) | ADDR_W'(smp_bin);
  assign rd_addr      = (ADDR_W'(read_column_i) << BIN_BITS) | ADDR_W'(rd_bin);
  assign is_sample    = (kind_i == KIND_SAMPLE);
  assign is_read      = (kind_i == KIND_READ);
  assign pos_in_range = (col_q < MaxColP);
  assign rd_col_ok    = ({5'b00000, read_column_i} < MaxColRd);

  // The memory read is issued on the transfer itself.
  assign ram_re    = cmd_i.accept & ((is_sample & pos_in_range) | (is_read & rd_col_ok));
  assign ram_raddr = is_read ? rd_addr : smp_addr;

  // Saturating increment of the count read back.
  assign inc_cnt = (ram_rdata != CountMax) ? ram_rdata + COUNT_WIDTH'(1) : ram_rdata;

  // A column of length zero behaves as a length of one.
  assign row_wrap = ({1'b0, row_q} + 33'd1) >= {1'b0, len_q};

  // Write port select: clearing pass, incremented count or cleared bin.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
    end else if (cmd_i.inc_write) begin
      ram_we    = 1'b1;
      ram_wdata = inc_cnt;
    end else if (cmd_i.rd_finish && col_ok_q && clr_rd_q) begin
      ram_we    = 1'b1;
    end
  end

  pcih_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration writes; indexes beyond the list are ignored.
  always_comb begin
    type_d = type_q;
    len_d  = len_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_TYPE:   type_d = cfg_data_i[1:0];
        CFG_COLUMN_LENGTH: len_d  = cfg_data_i;
        default: begin
          type_d = type_q;
        end
      endcase
    end
  end

  // Position counters and sticky flags.
  always_comb begin
    row_d     = row_q;
    col_d     = col_q;
    dropped_d = dropped_q;
    sat_d     = sat_q;
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clr_step) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
    end
    if (cmd_i.accept && is_sample) begin
      if (!pos_in_range) begin
        dropped_d = 1'b1;
      end
      if (row_wrap) begin
        row_d = '0;
        if (pos_in_range) begin
          col_d = col_q + COLP_W'(1);
        end
      end else begin
        row_d = row_q + 32'd1;
      end
    end
    if (cmd_i.accept && kind_i == KIND_RESTART) begin
      row_d = '0;
      col_d = '0;
    end
    if (cmd_i.inc_write && inc_cnt == CountMax) begin
      sat_d = 1'b1;
    end
  end

  // Result register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.rd_finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q      <= TYPE_U8;
      len_q       <= 32'd1;
      row_q       <= '0;
      col_q       <= '0;
      dropped_q   <= 1'b0;
      sat_q       <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      type_q      <= type_d;
      len_q       <= len_d;
      row_q       <= row_d;
      col_q       <= col_d;
      dropped_q   <= dropped_d;
      sat_q       <= sat_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Latch what the write-back or result step of an item needs.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q   <= ram_raddr;
      label_q  <= bin_label(type_q, 17'(rd_bin));
      col_ok_q <= rd_col_ok;
      clr_rd_q <= clear_after_read_i;
    end
  end

  // A read outside the build returns a count of zero.
  assign rd_cnt     = col_ok_q ? ram_rdata : '0;
  assign rd_cnt_ext = 64'(rd_cnt);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_finish) begin
      cnt_out_q   <= rd_cnt_ext[31:0];
      label_out_q <= label_q;
      drop_out_q  <= dropped_q;
      sat_out_q   <= sat_q;
    end
  end

  assign status_o.kind         = kind_i;
  assign status_o.pos_in_range = pos_in_range;
  assign status_o.out_free     = ~out_valid_q | out_ready_i;
  assign status_o.clr_last     = (clr_cnt_q == LastAddr);

  assign out_valid_o       = out_valid_q;
  assign bin_count_o       = cnt_out_q;
  assign bin_label_o       = label_out_q;
  assign samples_dropped_o = drop_out_q;
  assign count_saturated_o = sat_out_q;

endmodule

// ===== src/per_column_integer_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_column_integer_histogram: per-column histogram of 8/16-bit samples
// Counts samples into one bin array per column and returns bin reads.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the in_* valid/ready channel. A sample item adds one to the
// bin of its value in the current column; a read item returns one result on
// the out_* channel; a restart item zeroes the row and column positions.
// Configuration writes use the cfg_* channel, which is always ready.
// Sequence: a sample does a registered memory read, then a write back of
// the incremented count, and no new item is taken until that write back.
// A read waits until the result register is free and then loads its
// result into it. Restart items and samples beyond the last built column
// need no further step. The memory's single write port and registered read set this.
// Reset: the bin store is cleared by a pass over all MAX_COLUMNS * 2^BIN_BITS
// entries (262144 at the default build), one entry per cycle, during which
// in_ready_o stays low.
// Stall: a result waits in the output register while out_ready_i is low;
// the block keeps taking samples, and a further read holds until the
// waiting result has been transferred.
// ----------------------------------------------------------------------------
module per_column_integer_histogram #(
  parameter int BIN_BITS    = 16,
  parameter int MAX_COLUMNS = 4,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       kind_i,
  input  logic [15:0]                      sample_raw_i,
  input  logic [1:0]                       read_column_i,
  input  logic [15:0]                      read_bin_i,
  input  logic                             clear_after_read_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pcih_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [31:0]                      bin_count_o,
  output logic signed [16:0]               bin_label_o,
  output logic                             samples_dropped_o,
  output logic                             count_saturated_o
);
  import pcih_pkg::*;

  pcih_cmd_t    cmd;
  pcih_status_t status;

  // Configuration registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  pcih_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pcih_dp #(
    .BIN_BITS    (BIN_BITS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .kind_i             (kind_i),
    .sample_raw_i       (sample_raw_i),
    .read_column_i      (read_column_i),
    .read_bin_i         (read_bin_i),
    .clear_after_read_i (clear_after_read_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .bin_count_o        (bin_count_o),
    .bin_label_o        (bin_label_o),
    .samples_dropped_o  (samples_dropped_o),
    .count_saturated_o  (count_saturated_o)
  );

  // At most one memory-related command is active in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_step, cmd.accept, cmd.inc_write, cmd.rd_finish}))
    else $error("Controller issued overlapping commands.");

  // No input transfer is offered while the clearing pass runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> !in_ready_o)
    else $error("Input ready during the clearing pass.");

  // The count write-back directly follows the transfer of its sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.inc_write |-> $past(cmd.accept) && $past(kind_i) == KIND_SAMPLE)
    else $error("Count write-back without a preceding sample transfer.");

  // A result only appears after the controller finished a bin read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.rd_finish))
    else $error("Result valid without a finished bin read.");

endmodule

// ===== test/pcih_bin_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcih_bin_checker: bin count predictor and result checker
// Watches the item, configuration and result channels of the per-column
// histogram. It keeps its own copy of the bin counts, position counters and
// sticky flags, predicts the result of every bin read, and compares each
// result transfer field by field with the oldest outstanding read.
// ----------------------------------------------------------------------------
module pcih_bin_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [1:0]                       kind_i,
  input  logic [15:0]                      sample_raw_i,
  input  logic [1:0]                       read_column_i,
  input  logic [15:0]                      read_bin_i,
  input  logic                             clear_after_read_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [pcih_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [31:0]                      bin_count_i,
  input  logic signed [16:0]               bin_label_i,
  input  logic                             samples_dropped_i,
  input  logic                             count_saturated_i,
  output int unsigned                      pending_o,
  output int unsigned                      fail_count_o
);

  import pcih_pkg::*;

  localparam int unsigned NUM_COLUMNS = 4;
  localparam logic [31:0] COUNT_TOP   = 32'hFFFF_FFFF;
  localparam int          REPORT_MAX  = 10;

  // One predicted bin read result.
  typedef struct packed {
    logic [31:0] count;
    logic [16:0] label;
    logic        dropped;
    logic        saturated;
  } bin_read_t;

  // Bin counts keyed by {column, bin}; entries never touched are zero.
  logic [31:0] bin_tally [int unsigned];
  bin_read_t   reads_due [$];

  logic [1:0]  cur_type;
  logic [31:0] cur_length;
  logic [31:0] row_pos;
  int unsigned col_pos;
  logic        dropped_seen;
  logic        saturated_seen;
  int unsigned mismatches;

  // Bin index of a raw value: signed types are offset by half their range.
  function automatic logic [15:0] offset_bin(input logic [1:0] stype, input logic [15:0] raw);
    case (stype)
      TYPE_S8:  return {8'h00, raw[7:0] ^ 8'h80};
      TYPE_U8:  return {8'h00, raw[7:0]};
      TYPE_S16: return raw ^ 16'h8000;
      default:  return raw;
    endcase
  endfunction

  // Sample value a bin stands for, as 17-bit two's complement.
  function automatic logic [16:0] value_label(input logic [1:0] stype, input logic [15:0] bin);
    case (stype)
      TYPE_S8:  return {1'b0, bin} - 17'd128;
      TYPE_S16: return {1'b0, bin} - 17'h08000;
      default:  return {1'b0, bin};
    endcase
  endfunction

  function automatic logic [31:0] tally_at(input int unsigned addr);
    return bin_tally.exists(addr) ? bin_tally[addr] : 32'd0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_histogram
    bin_read_t   due;
    bin_read_t   seen;
    int unsigned addr;
    logic [31:0] tally;
    logic [15:0] bin;
    if (!rst_ni) begin
      bin_tally.delete();
      reads_due.delete();
      cur_type       = TYPE_U8;
      cur_length     = 32'd1;
      row_pos        = 32'd0;
      col_pos        = 0;
      dropped_seen   = 1'b0;
      saturated_seen = 1'b0;
      mismatches     = 0;
      pending_o      <= 0;
      fail_count_o   <= 0;
    end else begin
      // Register writes take effect for the items that follow them.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SAMPLE_TYPE:   cur_type = cfg_data_i[1:0];
          CFG_COLUMN_LENGTH: cur_length = cfg_data_i;
          default: ;
        endcase
      end

      // A result transfer is matched against the oldest outstanding read.
      if (out_valid_i && out_ready_i) begin
        seen = '{bin_count_i, bin_label_i, samples_dropped_i, count_saturated_i};
        if (reads_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t checker: result with no read outstanding: count=%0d label=%0d",
                     $realtime, bin_count_i, bin_label_i);
        end else begin
          due = reads_due.pop_front();
          if (seen != due) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t checker: read result mismatch", $realtime);
              $display("  expected count=%0d label=%0d dropped=%0b saturated=%0b",
                       due.count, $signed(due.label), due.dropped, due.saturated);
              $display("  got      count=%0d label=%0d dropped=%0b saturated=%0b",
                       seen.count, $signed(seen.label), seen.dropped, seen.saturated);
            end
          end
        end
      end

      // Item transfers update the predicted state.
      if (in_valid_i && in_ready_i) begin
        case (kind_i)
          KIND_SAMPLE: begin
            bin = offset_bin(cur_type, sample_raw_i);
            if (col_pos >= NUM_COLUMNS) begin
              dropped_seen = 1'b1;
            end else begin
              addr  = (col_pos << 16) | bin;
              tally = tally_at(addr);
              if (tally != COUNT_TOP) tally = tally + 32'd1;
              if (tally == COUNT_TOP) saturated_seen = 1'b1;
              bin_tally[addr] = tally;
            end
            // A zero column length acts as a length of one.
            if ({32'd0, row_pos} + 64'd1 >= {32'd0, cur_length}) begin
              row_pos = 32'd0;
              if (col_pos < NUM_COLUMNS) col_pos++;
            end else begin
              row_pos = row_pos + 32'd1;
            end
          end
          KIND_READ: begin
            bin       = offset_bin(cur_type, read_bin_i);
            addr      = (int'(read_column_i) << 16) | bin;
            due.count = (read_column_i < NUM_COLUMNS) ? tally_at(addr) : 32'd0;
            due.label = value_label(cur_type, bin);
            due.dropped   = dropped_seen;
            due.saturated = saturated_seen;
            reads_due.push_back(due);
            if (clear_after_read_i && read_column_i < NUM_COLUMNS) bin_tally[addr] = 32'd0;
          end
          KIND_RESTART: begin
            row_pos = 32'd0;
            col_pos = 0;
          end
          default: ;
        endcase
      end

      pending_o    <= reads_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== test/tb_per_column_integer_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_column_integer_histogram: stimulus and verdict for the histogram
// Drives a directed set of samples, reads and restarts over the type and
// column length extremes, then randomized phases of sample streams with
// reads of recently hit bins, under random idling on both channels. The
// checker beside the block predicts and compares every bin read.
// ----------------------------------------------------------------------------
module tb_per_column_integer_histogram;

  import pcih_pkg::*;

  localparam logic [1:0]             KIND_UNUSED    = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_B = 2'd3;
  // The reset clearing pass alone covers 262144 entries with no transfer.
  localparam int unsigned WATCHDOG_LIMIT = 1000000;
  localparam int          RANDOM_PHASES  = 9;
  localparam int          PHASE_ITEMS    = 50;

  logic                   clk              = 1'b0;
  logic                   rst_n            = 1'b0;
  logic                   in_valid         = 1'b0;
  logic                   in_ready;
  logic [1:0]             kind             = KIND_SAMPLE;
  logic [15:0]            sample_raw       = 16'd0;
  logic [1:0]             read_column      = 2'd0;
  logic [15:0]            read_bin         = 16'd0;
  logic                   clear_after_read = 1'b0;
  logic                   cfg_valid        = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index        = CFG_SAMPLE_TYPE;
  logic [31:0]            cfg_data         = 32'd0;
  logic                   out_valid;
  logic                   out_ready        = 1'b1;
  logic [31:0]            bin_count;
  logic signed [16:0]     bin_label;
  logic                   samples_dropped;
  logic                   count_saturated;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_stalls = 1'b1;

  always #2 clk = ~clk;

  per_column_integer_histogram dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .kind_i             (kind),
    .sample_raw_i       (sample_raw),
    .read_column_i      (read_column),
    .read_bin_i         (read_bin),
    .clear_after_read_i (clear_after_read),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .bin_count_o        (bin_count),
    .bin_label_o        (bin_label),
    .samples_dropped_o  (samples_dropped),
    .count_saturated_o  (count_saturated)
  );

  pcih_bin_checker bin_check (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .kind_i             (kind),
    .sample_raw_i       (sample_raw),
    .read_column_i      (read_column),
    .read_bin_i         (read_bin),
    .clear_after_read_i (clear_after_read),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .bin_count_i        (bin_count),
    .bin_label_i        (bin_label),
    .samples_dropped_i  (samples_dropped),
    .count_saturated_i  (count_saturated),
    .pending_o          (pending),
    .fail_count_o       (fail_count)
  );

  // The receiver drops ready in random bursts while stalls are enabled.
  always @(posedge clk) begin
    if (receiver_stalls && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_ready <= 1'b1;
    end
  end

  // End the run if no transfer happens on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // Offer one item and hold it until its transfer, then maybe idle a while.
  task automatic send_item(input logic [1:0] k, input logic [15:0] raw,
                           input logic [1:0] col, input logic [15:0] rbin,
                           input logic clr);
    in_valid         <= 1'b1;
    kind             <= k;
    sample_raw       <= raw;
    read_column      <= col;
    read_bin         <= rbin;
    clear_after_read <= clr;
    do @(posedge clk); while (!in_ready);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off new items until every read has returned and samples have retired.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One randomized phase: a restart, then samples, reads, restarts and unused kinds,
  // with values drawn mostly from a small pool so that reads of the same values find populated bins.
  task automatic random_phase(input logic [1:0] stype, input logic [31:0] len);
    logic [15:0] pool [6];
    logic [15:0] raw;
    logic [15:0] rbin;
    int          sent;
    int          pick;
    foreach (pool[i]) pool[i] = rnd16();
    write_reg(CFG_SAMPLE_TYPE, {$urandom_range(0, 1) ? 30'($urandom) : 30'd0, stype});
    write_reg(CFG_COLUMN_LENGTH, len);
    send_item(KIND_RESTART, rnd16(), 2'($urandom), rnd16(), 1'($urandom));
    sent = 1;
    while (sent < PHASE_ITEMS) begin
      raw  = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 5)] : rnd16();
      rbin = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 5)] : rnd16();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(KIND_SAMPLE, raw, 2'($urandom), rnd16(), 1'($urandom));
        sent++;
      end else if (pick < 88) begin
        send_item(KIND_READ, rnd16(), 2'($urandom), rbin, $urandom_range(0, 3) == 0);
        sent++;
      end else if (pick < 94) begin
        send_item(KIND_RESTART, rnd16(), 2'($urandom), rnd16(), 1'($urandom));
        sent++;
      end else begin
        send_item(KIND_UNUSED, rnd16(), 2'($urandom), rnd16(), 1'($urandom));
      end
    end
    drain_results();
  endtask

  initial begin : stimulus
    logic [31:0] len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: unsigned 8-bit, one sample per column. The fifth sample
    // lands past the last column and is dropped.
    send_item(KIND_SAMPLE, 16'h00FF, 2'd3, 16'hFFFF, 1'b1);
    send_item(KIND_SAMPLE, 16'hFF00, 2'd0, 16'h0000, 1'b0);
    send_item(KIND_SAMPLE, 16'hFFFF, 2'd3, 16'hFFFF, 1'b1);
    send_item(KIND_SAMPLE, 16'h0000, 2'd0, 16'h0000, 1'b0);
    send_item(KIND_SAMPLE, 16'h1234, 2'd1, 16'h5678, 1'b1);
    send_item(KIND_UNUSED, 16'hFFFF, 2'd3, 16'hFFFF, 1'b1);
    // High index bits are masked off for 8-bit types.
    send_item(KIND_READ, 16'h0000, 2'd0, 16'hFFFF, 1'b1);
    send_item(KIND_READ, 16'hFFFF, 2'd0, 16'h00FF, 1'b0);
    send_item(KIND_READ, 16'hFFFF, 2'd1, 16'h0000, 1'b0);
    send_item(KIND_RESTART, 16'h0000, 2'd2, 16'h0000, 1'b0);
    send_item(KIND_SAMPLE, 16'h0080, 2'd0, 16'h0000, 1'b0);
    send_item(KIND_READ, 16'h0000, 2'd0, 16'h0080, 1'b1);
    drain_results();

    // Signed 16-bit with a zero column length; bins survive the type change.
    write_reg(CFG_UNMAPPED_A, $urandom);
    write_reg(CFG_UNMAPPED_B, $urandom);
    write_reg(CFG_SAMPLE_TYPE, {30'd0, TYPE_S16});
    write_reg(CFG_COLUMN_LENGTH, 32'd0);
    send_item(KIND_SAMPLE, 16'h8000, 2'd1, 16'h0000, 1'b0);
    send_item(KIND_SAMPLE, 16'h7FFF, 2'd2, 16'hFFFF, 1'b1);
    send_item(KIND_READ, 16'h0000, 2'd1, 16'h8000, 1'b0);
    send_item(KIND_READ, 16'h0000, 2'd1, 16'h7FFF, 1'b0);
    send_item(KIND_READ, 16'h0000, 2'd3, 16'hFFFF, 1'b1);
    drain_results();

    // Signed 8-bit with the longest column: everything stays in column 0.
    write_reg(CFG_SAMPLE_TYPE, {30'h3FFF_FFFF, TYPE_S8});
    write_reg(CFG_COLUMN_LENGTH, 32'hFFFF_FFFF);
    send_item(KIND_RESTART, 16'hFFFF, 2'd3, 16'hFFFF, 1'b1);
    send_item(KIND_SAMPLE, 16'h0080, 2'd0, 16'h0000, 1'b0);
    send_item(KIND_SAMPLE, 16'h807F, 2'd0, 16'h0000, 1'b0);
    send_item(KIND_READ, 16'h0000, 2'd0, 16'hFF80, 1'b0);
    send_item(KIND_READ, 16'h0000, 2'd0, 16'h007F, 1'b1);
    drain_results();

    // Unsigned 16-bit, two samples per column.
    write_reg(CFG_SAMPLE_TYPE, {30'd0, TYPE_U16});
    write_reg(CFG_COLUMN_LENGTH, 32'd2);
    send_item(KIND_SAMPLE, 16'hFFFF, 2'd0, 16'h0000, 1'b0);
    send_item(KIND_SAMPLE, 16'h0001, 2'd0, 16'h0000, 1'b0);
    send_item(KIND_READ, 16'h0000, 2'd0, 16'hFFFF, 1'b0);
    drain_results();

    // Randomized phases; the last ones run without idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sender_idles    = (p < RANDOM_PHASES - 2) && (p % 3 != 2);
      receiver_stalls = (p < RANDOM_PHASES - 2) && (p % 4 != 3);
      case ($urandom_range(0, 5))
        0:       len = 32'd1;
        1:       len = 32'd0;
        2:       len = $urandom_range(2, 8);
        3:       len = $urandom_range(9, 40);
        4:       len = 32'hFFFF_FFFF;
        default: len = $urandom;
      endcase
      random_phase(2'($urandom), len);
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
